>>> sv/usbc_pkg.sv
// usbc_pkg: shared types, widths and constants for the RGB unsharp blur core.
// No dependencies; imported by every module of the block but usbc_ram.
`default_nettype none
package usbc_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_RADIUS_DEF = 4;

  localparam int PIX_W   = 8;
  localparam int NUM_CH  = 3;
  localparam int TAP_W   = 7;
  localparam int WID_W   = 11;   // frame_width register
  localparam int HGT_W   = 12;   // frame_height register
  localparam int RAD_W   = 3;    // blur_radius register
  localparam int TAPS_W  = 63;   // tap_weights register
  localparam int COL_W   = 10;   // in_column counter
  localparam int ROW_W   = 12;   // in_row counter
  localparam int OIDX_W  = 22;   // out_index counter
  localparam int KIDX_W  = 4;    // tap index 0..8
  localparam int ACC_W   = 19;   // 9 * 127 * 255 fits
  localparam int TSUM_W  = 11;   // 9 * 127 fits
  localparam int DVW     = 22;   // divider dividend width
  localparam int DSW     = 11;   // divider divisor width
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 63;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLUR_RADIUS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_WEIGHTS  = 2'd3;

  localparam logic [WID_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
  localparam logic [HGT_W-1:0]  RST_FRAME_HEIGHT = 12'd480;
  localparam logic [RAD_W-1:0]  RST_BLUR_RADIUS  = 3'd1;
  localparam logic [TAPS_W-1:0] RST_TAP_WEIGHTS  = 63'd1569375;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  typedef struct packed {
    logic             req_type;
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic             frame_last;
  } out_item_t;

  typedef logic [NUM_CH-1:0][DVW-1:0] div_lanes_t;
  typedef logic [NUM_CH-1:0][DSW-1:0] div_rems_t;

  typedef struct packed {
    logic           start;
    logic [DSW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WR_REQ,
    ST_WR_WAIT,
    ST_POS_DIV,
    ST_POS_WAIT,
    ST_F_ADDR,
    ST_F_REQ,
    ST_F_WAIT,
    ST_F_DATA,
    ST_V_DIV,
    ST_V_WAIT,
    ST_H_DIV,
    ST_H_WAIT,
    ST_FINAL
  } state_t;

endpackage
`default_nettype wire

>>> sv/rgb_unsharp_separable_blur_core.sv
// rgb_unsharp_separable_blur_core: top level, sequencer and datapath.
// Depends on usbc_pkg, usbc_ram, usbc_div, usbc_wrap.
//
// Usage:
//   in_valid/in_ready carry one pixel item or drain tick per transaction;
//   out_valid/out_ready carry one sharpened pixel per transaction.
//   cfg_we/cfg_index/cfg_data write a register, block idle.
//   Items are handled one at a time. A transaction that makes no result
//   is only checked (drain tick) or also written to the line store
//   (pixel). One that makes a result also runs the output pass: one
//   divide for position, then per line store fetch an index multiply,
//   the 3-stage modulo and a RAM read. Its length is set by the single
//   RAM read port and the shared bit-serial divider. Radius 0 fetches
//   only the centre pixel and skips the blur divides.
//   Output n appears with input n+R*W+R; drain ticks flush the frame.
//   A finished result sits in the output register; the next item is taken
//   while it waits, and the block holds in its last step if the register
//   is still full when the next result is ready.
//   Reset (rst, synchronous) restores register defaults and clears the
//   counters; the line store is not cleared and needs no clearing pass.
`default_nettype none
module rgb_unsharp_separable_blur_core
  import usbc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data
);

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS;
  localparam int XW    = $clog2(4095 * MAX_WIDTH + 1024);
  localparam int AW    = $clog2(DEPTH);
  localparam int NT    = 2 * MAX_RADIUS + 1;
  localparam int WORD_W = NUM_CH * PIX_W;

  // configuration
  logic [WID_W-1:0]  frame_width;
  logic [HGT_W-1:0]  frame_height;
  logic [RAD_W-1:0]  blur_radius;
  logic [TAPS_W-1:0] tap_weights;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RST_FRAME_WIDTH;
      frame_height <= RST_FRAME_HEIGHT;
      blur_radius  <= RST_BLUR_RADIUS;
      tap_weights  <= RST_TAP_WEIGHTS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[WID_W-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[HGT_W-1:0];
        CFG_BLUR_RADIUS:  blur_radius  <= cfg_data[RAD_W-1:0];
        CFG_TAP_WEIGHTS:  tap_weights  <= cfg_data[TAPS_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WID_W-1:0] w_eff;
  logic [HGT_W-1:0] h_eff;
  logic [RAD_W-1:0] r_eff;
  logic [KIDX_W-1:0] two_r;

  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) begin
      w_eff = WID_W'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end
    h_eff = (frame_height == '0) ? HGT_W'(1) : frame_height;
    r_eff = (32'(blur_radius) > MAX_RADIUS) ? RAD_W'(MAX_RADIUS) : blur_radius;
    two_r = {r_eff, 1'b0};
  end

  // tap sum, tracked every cycle from the registers
  logic [TSUM_W-1:0] tsum, tsum_next;

  always_comb begin
    tsum_next = '0;
    for (int i = 0; i < NT; i++) begin
      if (i <= 32'(two_r)) begin
        tsum_next = tsum_next + TSUM_W'(tap_weights[TAP_W*i +: TAP_W]);
      end
    end
    if (tsum_next == '0) begin
      tsum_next = TSUM_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    tsum <= tsum_next;
  end

  // sequencer state and counters
  state_t state, state_next;

  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic [OIDX_W-1:0] out_index;

  in_item_t          item;
  logic [XW-1:0]     x_reg;
  logic [HGT_W-1:0]  oy;
  logic [WID_W-1:0]  ox;
  logic [KIDX_W-1:0] kxi, kyi;
  logic              center;
  logic [NUM_CH-1:0][ACC_W-1:0] vacc, hacc;
  logic [NUM_CH-1:0][PIX_W-1:0] src, blur;

  // submodule wiring
  logic             wrap_iv, wrap_ov;
  logic [AW-1:0]    wrap_addr;
  logic             ram_we, ram_re;
  logic [WORD_W-1:0] ram_rdata;
  div_req_t         dreq;
  div_lanes_t       ddividend, dquot;
  div_rems_t        drem;
  logic             ddone;

  usbc_wrap #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_RADIUS(MAX_RADIUS)
  ) u_wrap (
    .clk  (clk),
    .rst  (rst),
    .in_v (wrap_iv),
    .x    (x_reg),
    .out_v(wrap_ov),
    .addr (wrap_addr)
  );

  usbc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wrap_addr),
    .wdata({item.red_in, item.green_in, item.blue_in}),
    .re   (ram_re),
    .raddr(wrap_addr),
    .rdata(ram_rdata)
  );

  usbc_div u_div (
    .clk     (clk),
    .rst     (rst),
    .req     (dreq),
    .dividend(ddividend),
    .done    (ddone),
    .quot    (dquot),
    .rem     (drem)
  );

  // datapath helpers
  logic [TAP_W-1:0] tap_y, tap_x;
  logic signed [HGT_W+1:0] srow;
  logic signed [WID_W+1:0] scol;
  logic [HGT_W-1:0] frow;
  logic [WID_W-1:0] fcol;
  logic [23:0]      lin_fetch, lin_write, thresh;
  logic             wr_last_col;
  logic [OIDX_W:0]  n_plus, total;
  logic             out_load;
  out_item_t        result;

  always_comb begin
    tap_y = tap_weights[TAP_W*kyi +: TAP_W];
    tap_x = tap_weights[TAP_W*kxi +: TAP_W];

    srow = $signed({2'b00, oy}) + $signed({10'b0, kyi}) - $signed({11'b0, r_eff});
    if (srow < 0) begin
      frow = '0;
    end else if (srow > $signed({2'b00, h_eff - 1'b1})) begin
      frow = h_eff - 1'b1;
    end else begin
      frow = srow[HGT_W-1:0];
    end

    scol = $signed({2'b00, ox}) + $signed({9'b0, kxi}) - $signed({10'b0, r_eff});
    if (scol < 0) begin
      fcol = '0;
    end else if (scol > $signed({2'b00, w_eff - 1'b1})) begin
      fcol = w_eff - 1'b1;
    end else begin
      fcol = scol[WID_W-1:0];
    end

    lin_fetch   = 24'(frow) * 24'(w_eff) + 24'(fcol);
    lin_write   = 24'(in_row) * 24'(w_eff) + 24'(in_column);
    thresh      = 24'(r_eff) * 24'(w_eff) + 24'(r_eff);
    wr_last_col = ({1'b0, in_column} + 1'b1) >= w_eff;
    n_plus      = {1'b0, out_index} + 1'b1;
    total       = (OIDX_W+1)'(24'(w_eff) * 24'(h_eff));
  end

  // sharpen: s + |s - b|, clamped
  always_comb begin
    logic [NUM_CH-1:0][PIX_W-1:0] sharp;
    logic [PIX_W-1:0] d;
    logic [PIX_W:0]   v;
    for (int c = 0; c < NUM_CH; c++) begin
      d = (src[c] > blur[c]) ? src[c] - blur[c] : blur[c] - src[c];
      v = {1'b0, src[c]} + {1'b0, d};
      sharp[c] = v[PIX_W] ? PIX_MAX : v[PIX_W-1:0];
    end
    result.red_out    = sharp[2];
    result.green_out  = sharp[1];
    result.blue_out   = sharp[0];
    result.frame_last = n_plus >= total;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if (in_row >= h_eff) begin
          state_next = ST_POS_DIV;
        end else if (item.req_type) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_WR_REQ;
        end
      end
      ST_WR_REQ:   state_next = ST_WR_WAIT;
      ST_WR_WAIT: begin
        if (wrap_ov) begin
          state_next = (24'(x_reg) >= thresh) ? ST_POS_DIV : ST_IDLE;
        end
      end
      ST_POS_DIV:  state_next = ST_POS_WAIT;
      ST_POS_WAIT: if (ddone) state_next = ST_F_ADDR;
      ST_F_ADDR:   state_next = ST_F_REQ;
      ST_F_REQ:    state_next = ST_F_WAIT;
      ST_F_WAIT:   if (wrap_ov) state_next = ST_F_DATA;
      ST_F_DATA: begin
        if (center) begin
          state_next = (r_eff == '0) ? ST_FINAL : ST_F_ADDR;
        end else begin
          state_next = (kyi == two_r) ? ST_V_DIV : ST_F_ADDR;
        end
      end
      ST_V_DIV:    state_next = ST_V_WAIT;
      ST_V_WAIT: begin
        if (ddone) begin
          state_next = (kxi == two_r) ? ST_H_DIV : ST_F_ADDR;
        end
      end
      ST_H_DIV:    state_next = ST_H_WAIT;
      ST_H_WAIT:   if (ddone) state_next = ST_FINAL;
      ST_FINAL:    if (!out_valid || out_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready     = (state == ST_IDLE);
    wrap_iv      = (state == ST_WR_REQ) || (state == ST_F_REQ);
    ram_we       = (state == ST_WR_WAIT) && wrap_ov;
    ram_re       = (state == ST_F_WAIT) && wrap_ov;
    dreq.start   = (state == ST_POS_DIV) || (state == ST_V_DIV) || (state == ST_H_DIV);
    dreq.divisor = (state == ST_POS_DIV) ? w_eff : DSW'(tsum);
    out_load     = (state == ST_FINAL) && (!out_valid || out_ready);
    for (int c = 0; c < NUM_CH; c++) begin
      case (state)
        ST_POS_DIV: ddividend[c] = DVW'(out_index);
        ST_V_DIV:   ddividend[c] = DVW'(vacc[c]);
        default:    ddividend[c] = DVW'(hacc[c]);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row    <= '0;
      out_index <= '0;
    end else if (ram_we) begin
      if (wr_last_col) begin
        in_column <= '0;
        in_row    <= in_row + 1'b1;
      end else begin
        in_column <= in_column + 1'b1;
      end
    end else if (out_load) begin
      if (result.frame_last) begin
        in_column <= '0;
        in_row    <= '0;
        out_index <= '0;
      end else begin
        out_index <= n_plus[OIDX_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= result;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) item <= in_data;
      end
      ST_CHECK: begin
        x_reg <= XW'(lin_write);
      end
      ST_POS_WAIT: begin
        if (ddone) begin
          oy     <= (dquot[0] > DVW'(h_eff - 1'b1)) ? h_eff - 1'b1 : dquot[0][HGT_W-1:0];
          ox     <= drem[0];
          kxi    <= KIDX_W'(r_eff);
          kyi    <= KIDX_W'(r_eff);
          center <= 1'b1;
        end
      end
      ST_F_ADDR: begin
        x_reg <= XW'(lin_fetch);
      end
      ST_F_DATA: begin
        if (center) begin
          for (int c = 0; c < NUM_CH; c++) begin
            src[c]  <= ram_rdata[PIX_W*c +: PIX_W];
            blur[c] <= ram_rdata[PIX_W*c +: PIX_W];
          end
          center <= 1'b0;
          kxi    <= '0;
          kyi    <= '0;
          vacc   <= '0;
          hacc   <= '0;
        end else begin
          for (int c = 0; c < NUM_CH; c++) begin
            vacc[c] <= vacc[c] + ACC_W'(tap_y) * ACC_W'(ram_rdata[PIX_W*c +: PIX_W]);
          end
          kyi <= kyi + 1'b1;
        end
      end
      ST_V_WAIT: begin
        if (ddone) begin
          for (int c = 0; c < NUM_CH; c++) begin
            hacc[c] <= hacc[c] + ACC_W'(tap_x) *
                       ((dquot[c] > DVW'(PIX_MAX)) ? ACC_W'(PIX_MAX) : ACC_W'(dquot[c][PIX_W-1:0]));
          end
          kxi  <= kxi + 1'b1;
          kyi  <= '0;
          vacc <= '0;
        end
      end
      ST_H_WAIT: begin
        if (ddone) begin
          for (int c = 0; c < NUM_CH; c++) begin
            blur[c] <= (dquot[c] > DVW'(PIX_MAX)) ? PIX_MAX : dquot[c][PIX_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> sv/usbc_ram.sv
// usbc_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none
module usbc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 9224
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> sv/usbc_div.sv
// usbc_div: three-lane restoring divider, shared divisor, one bit per cycle.
// Depends on usbc_pkg.
`default_nettype none
module usbc_div
  import usbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire div_req_t   req,
  input  wire div_lanes_t dividend,
  output logic            done,
  output div_lanes_t      quot,
  output div_rems_t       rem
);

  localparam int CNT_W = $clog2(DVW + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DSW-1:0]   dsr;
  div_lanes_t       quot_next;
  div_rems_t        rem_next;

  always_comb begin
    logic [DSW:0] t;
    for (int c = 0; c < NUM_CH; c++) begin
      t = {rem[c], quot[c][DVW-1]};
      if (t >= {1'b0, dsr}) begin
        rem_next[c]  = DSW'(t - {1'b0, dsr});
        quot_next[c] = {quot[c][DVW-2:0], 1'b1};
      end else begin
        rem_next[c]  = t[DSW-1:0];
        quot_next[c] = {quot[c][DVW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(DVW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= req.divisor;
    end else if (busy) begin
      quot <= quot_next;
      rem  <= rem_next;
    end
  end

endmodule
`default_nettype wire

>>> sv/usbc_wrap.sv
// usbc_wrap: reduces a linear pixel index modulo the line store depth.
// Three-stage reciprocal multiply with one correction. Depends on usbc_pkg.
`default_nettype none
module usbc_wrap
  import usbc_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_RADIUS = MAX_RADIUS_DEF
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst,
  input  wire logic                                       in_v,
  input  wire logic [$clog2(4095*MAX_WIDTH+1024)-1:0]     x,
  output logic                                            out_v,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH+2*MAX_RADIUS)-1:0] addr
);

  localparam int DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS;
  localparam int XW    = $clog2(4095 * MAX_WIDTH + 1024);
  localparam int AW    = $clog2(DEPTH);
  localparam int RECIP = (2 ** XW) / DEPTH;
  localparam int RW    = $clog2(RECIP + 1);

  logic [2:0]       v;
  logic [XW-1:0]    x1, x2;
  logic [XW+RW-1:0] prod;
  logic [XW-1:0]    qd;
  logic [XW-1:0]    diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[1:0], in_v};
    end
  end

  // estimate is floor(x/DEPTH) or one less
  always_comb begin
    diff = x2 - qd;
    if (diff >= XW'(DEPTH)) begin
      diff = diff - XW'(DEPTH);
    end
  end

  always_ff @(posedge clk) begin
    x1   <= x;
    prod <= (XW+RW)'(x) * (XW+RW)'(RECIP);
    x2   <= x1;
    qd   <= XW'(XW'(prod[XW+RW-1:XW]) * XW'(DEPTH));
    addr <= AW'(diff);
  end

  assign out_v = v[2];

endmodule
`default_nettype wire

>>> sv/usbc_checker.sv
// usbc_checker: port-level assertions for the blur core, bound to the top.
// Depends on usbc_pkg and rgb_unsharp_separable_blur_core.
`default_nettype none
module usbc_checker
  import usbc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire in_item_t              in_data,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire out_item_t             out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // waiting input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("waiting input changed or dropped");

  // one item at a time: busy right after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken on two consecutive cycles");

  // a result is produced only while the input side is busy
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared while block was idle");

  // nothing left in the output register after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rgb_unsharp_separable_blur_core usbc_checker u_usbc_checker (.*);
`default_nettype wire
